// ===== rtl/core/qfcl_pkg.sv =====
package qfcl_pkg;

    // Fixed width of a vertex index and of a component label
    localparam int VERTEX_W = 6;

    // Width of the packed stream data words (two vertex fields, padded to bytes)
    localparam int TDATA_W = 16;

    // Default sizes handed to the top level
    localparam int DEF_NUM_VERTICES = 64;
    localparam int DEF_BATCH_SIZE   = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // take the request on the input channel into the edge register
        logic apply;      // restore/merge, buffer the source, advance the batch count
        logic load;       // load the output register from the buffer read port
        logic read_next;  // step the buffer read pointer
    } qfcl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic run_end;    // the edge being applied closes the batch
        logic rd_last;    // the read pointer sits on the final buffered source
        logic out_free;   // the output register can take a new result this cycle
    } qfcl_status_t;

endpackage

// ===== rtl/core/qfcl_ram.sv =====
module qfcl_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/qfcl_ctrl.sv =====
module qfcl_ctrl
    import qfcl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  qfcl_status_t status,
    output qfcl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.run_end ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                // Buffer address is presented; data is registered next cycle.
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.rd_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.read_next = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/qfcl_datapath.sv =====
module qfcl_datapath
    import qfcl_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES,
    parameter int BATCH_SIZE   = DEF_BATCH_SIZE
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  qfcl_cmd_t           cmd,
    output qfcl_status_t        status,
    input  logic [VERTEX_W-1:0] in_src,
    input  logic [VERTEX_W-1:0] in_dst,
    input  logic                in_end,
    input  logic                in_fresh,
    input  logic                m_tready,
    output logic                out_valid,
    output logic [VERTEX_W-1:0] out_src,
    output logic [VERTEX_W-1:0] out_label,
    output logic                out_last
);

    // Only vertices reachable by a 6-bit index need a table entry.
    localparam int TD    = (NUM_VERTICES < (1 << VERTEX_W)) ? NUM_VERTICES : (1 << VERTEX_W);
    localparam int TW    = $clog2(TD);
    localparam int AW    = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int CNT_W = $clog2(BATCH_SIZE + 1);
    localparam int NV_W  = 11;

    // Edge register
    logic [VERTEX_W-1:0] src_reg, dst_reg;
    logic                end_reg, fresh_reg;

    // Label table in flip-flops
    logic [VERTEX_W-1:0] tbl_reg  [TD];
    logic [VERTEX_W-1:0] tbl_next [TD];

    // Batch bookkeeping
    logic [CNT_W-1:0] count_reg, count_next, count_plus;
    logic [AW-1:0]    last_idx_reg, last_idx_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic             batch_full;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0] out_src_reg, out_label_reg;
    logic                out_last_reg;

    logic [VERTEX_W-1:0] ram_rd_data;
    logic [VERTEX_W-1:0] ls, ld;
    logic                src_ok, dst_ok, rd_ok;
    logic [VERTEX_W-1:0] rd_label;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            src_reg   <= in_src;
            dst_reg   <= in_dst;
            end_reg   <= in_end;
            fresh_reg <= in_fresh;
        end
    end

    assign src_ok = NV_W'(src_reg) < NV_W'(NUM_VERTICES);
    assign dst_ok = NV_W'(dst_reg) < NV_W'(NUM_VERTICES);

    // Endpoint labels, seen through the identity restore when it applies.
    always_comb begin
        ls = fresh_reg ? src_reg : tbl_reg[src_reg[TW-1:0]];
        ld = fresh_reg ? dst_reg : tbl_reg[dst_reg[TW-1:0]];
    end

    // Every entry compares against the destination label in parallel.
    always_comb begin
        logic [VERTEX_W-1:0] base;
        for (int i = 0; i < TD; i++) begin
            base = fresh_reg ? VERTEX_W'(i) : tbl_reg[i];
            if (cmd.apply) begin
                tbl_next[i] = (src_ok && dst_ok && (base == ld)) ? ls : base;
            end else begin
                tbl_next[i] = tbl_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TD; i++) begin
                tbl_reg[i] <= VERTEX_W'(i);
            end
        end else begin
            tbl_reg <= tbl_next;
        end
    end

    assign count_plus     = count_reg + CNT_W'(1);
    assign batch_full     = (count_plus == CNT_W'(BATCH_SIZE));
    assign status.run_end = end_reg || batch_full;

    always_comb begin
        count_next    = count_reg;
        last_idx_next = last_idx_reg;
        rd_idx_next   = rd_idx_reg;
        if (cmd.apply) begin
            count_next    = status.run_end ? '0 : count_plus;
            last_idx_next = count_reg[AW-1:0];
            rd_idx_next   = '0;
        end else if (cmd.read_next) begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            last_idx_reg <= '0;
            rd_idx_reg   <= '0;
        end else begin
            count_reg    <= count_next;
            last_idx_reg <= last_idx_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    assign status.rd_last = (rd_idx_reg == last_idx_reg);

    qfcl_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (BATCH_SIZE)
    ) u_src_buf (
        .aclk    (aclk),
        .wr_en   (cmd.apply),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (src_reg),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    // A vertex outside the graph reports its own index as its label.
    assign rd_ok    = NV_W'(ram_rd_data) < NV_W'(NUM_VERTICES);
    assign rd_label = rd_ok ? tbl_reg[ram_rd_data[TW-1:0]] : ram_rd_data;

    assign status.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_src_reg   <= ram_rd_data;
            out_label_reg <= rd_label;
            out_last_reg  <= status.rd_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_src   = out_src_reg;
    assign out_label = out_label_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/quick_find_component_labeler_top.sv =====
// Quick-find connected-component labeller. Each request on the slave side is one graph edge;
// when its endpoints carry different labels, every vertex holding the destination's label
// takes the source's label, and with tuser set the identity labelling is restored before the
// edge merges. The source of every edge is buffered, and when a batch closes (tlast on the
// edge, or BATCH_SIZE sources buffered) the block sends one request per buffered source, in
// arrival order, carrying the source and its label after the closing edge has merged, with
// tlast on the final one. An edge is first captured into the edge register, and then the whole
// flip-flop label table compares and relabels in parallel, so the slave side takes no new edge
// until the previous one has merged. A closing edge is followed by an output run in which each
// source is read through the registered source buffer RAM and then loaded into the output
// register before the next is read; the run stalls whenever the master side holds tready low.
// The last result may wait in the output register while the next edge is already being
// accepted. No clearing pass is needed after reset.
module quick_find_component_labeler_top
    import qfcl_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES,
    parameter int BATCH_SIZE   = DEF_BATCH_SIZE
) (
    input  logic               aclk,
    input  logic               aresetn,

    // Edge input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [5:0] src_vertex, [11:6] dst_vertex, [15:12] zero
    input  logic               s_tlast,   // batch_end
    input  logic               s_tuser,   // [0] new_graph

    // Label results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [5:0] source_echo, [11:6] component_label, [15:12] zero
    output logic               m_tlast    // last_of_batch
);

    qfcl_cmd_t           cmd;
    qfcl_status_t        status;
    logic [VERTEX_W-1:0] out_src;
    logic [VERTEX_W-1:0] out_label;

    // The controller sequences capture, merge and the output run.
    qfcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the label table, the source buffer and the output register.
    qfcl_datapath #(
        .NUM_VERTICES (NUM_VERTICES),
        .BATCH_SIZE   (BATCH_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_src    (s_tdata[VERTEX_W-1:0]),
        .in_dst    (s_tdata[2*VERTEX_W-1:VERTEX_W]),
        .in_end    (s_tlast),
        .in_fresh  (s_tuser),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_src   (out_src),
        .out_label (out_label),
        .out_last  (m_tlast)
    );

    // Pack the result fields from the lowest bit up, zero padded to whole bytes.
    assign m_tdata = {(TDATA_W - 2*VERTEX_W)'(0), out_label, out_src};

endmodule

// ===== rtl/core/qfcl_checker.sv =====
module qfcl_checker
    import qfcl_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // An edge must merge before the next is taken, so the slave side closes right after a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // Mid-run, the block must not take new edges.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("edge accepted while an output run is still in progress");

    // A stalled result stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed or was dropped");

endmodule

bind quick_find_component_labeler_top qfcl_checker u_qfcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
